[rtl/core/rcfd_pkg.sv]
`default_nettype none

package rcfd_pkg;

   // Frame geometry
   localparam int CHANNEL_COUNT       = 16;
   localparam int MAX_FRAME_BYTES     = 35;
   localparam int REVERSIBLE_CHANNELS = 12;
   localparam int MASK_W              = 12;
   localparam int REV_LIMIT           = (REVERSIBLE_CHANNELS < MASK_W) ?
                                        REVERSIBLE_CHANNELS : MASK_W;

   localparam int SBUS_LEN   = 25;
   localparam int SRXL_LEN   = 35;
   localparam int FOOTER_POS = 24;

   // Widths
   localparam int BYTE_W   = 8;
   localparam int POS_W    = 6;
   localparam int CHAN_W   = 4;
   localparam int VALUE_W  = 16;
   localparam int COUNT_W  = 16;
   localparam int SBUS_W   = 11;
   localparam int ACC_W    = 18;
   localparam int NBITS_W  = 5;
   localparam int PADDR_W  = 3;
   localparam int PDATA_W  = 32;

   // Frame markers
   localparam logic [BYTE_W-1:0] SBUS_HEADER = 8'h0F;
   localparam logic [BYTE_W-1:0] SBUS_FOOTER = 8'h00;
   localparam logic [BYTE_W-1:0] SRXL_HEADER = 8'hA2;

   localparam logic [VALUE_W-1:0] REV_BASE   = 16'd4095;
   localparam logic [VALUE_W-1:0] REV_ENABLE =
      VALUE_W'((32'd1 << REV_LIMIT) - 32'd1);

   // Protocol mode codes
   localparam logic MODE_SBUS = 1'b0;
   localparam logic MODE_SRXL = 1'b1;

   // Register word indexes
   localparam logic REG_MODE = 1'b0;
   localparam logic REG_MASK = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_ERROR,
      ST_FETCH,
      ST_LOAD,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic store;
      logic start_decode;
      logic fetch;
      logic load_byte;
      logic emit;
      logic load_err;
   } cmd_type;

   typedef struct packed {
      logic frame_done;
      logic frame_ok;
      logic bits_enough;
      logic last_chan;
      logic out_free;
   } status_type;

endpackage

`default_nettype wire

[rtl/core/rcfd_ram.sv]
`default_nettype none

module rcfd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 35
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[rtl/core/rcfd_datapath.sv]
`default_nettype none

module rcfd_datapath (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire rcfd_pkg::cmd_type              cmd,
   output rcfd_pkg::status_type                st,
   input  wire logic                           mode,
   input  wire logic [rcfd_pkg::MASK_W-1:0]    reverse_mask,
   input  wire logic [rcfd_pkg::BYTE_W-1:0]    rx_byte,
   input  wire logic                           rsp_ready,
   output logic                                rsp_valid,
   output logic      [rcfd_pkg::CHAN_W-1:0]    rsp_channel_index,
   output logic      [rcfd_pkg::VALUE_W-1:0]   rsp_channel_value,
   output logic                                rsp_frame_good,
   output logic      [rcfd_pkg::COUNT_W-1:0]   rsp_error_total,
   output logic                                rsp_last_of_frame
);

   import rcfd_pkg::*;

   logic [POS_W-1:0]   pos_ff, pos_in, store_pos, next_pos, frame_len;
   logic [POS_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [BYTE_W-1:0]  hdr_ff, hdr_in, ftr_ff, ftr_in, ram_rdata;
   logic [ACC_W-1:0]   acc_ff, acc_in;
   logic [NBITS_W-1:0] nbits_ff, nbits_in;
   logic [CHAN_W-1:0]  chan_ff, chan_in;
   logic [COUNT_W-1:0] bad_ff, bad_in;
   logic [VALUE_W-1:0] raw_value, rev_mask16, chan_value;
   logic               out_load;

   logic               valid_ff, valid_in, good_ff, good_in, last_ff, last_in;
   logic [CHAN_W-1:0]  index_ff, index_in;
   logic [VALUE_W-1:0] value_ff, value_in;
   logic [COUNT_W-1:0] total_ff, total_in;

   rcfd_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (MAX_FRAME_BYTES)
   ) u_frame_ram (
      .clock   (clock),
      .wr_en   (cmd.store),
      .wr_addr (store_pos),
      .wr_data (rx_byte),
      .rd_en   (cmd.fetch),
      .rd_addr (rd_ptr_ff),
      .rd_data (ram_rdata)
   );

   // Byte collection
   always_comb begin
      store_pos = (pos_ff >= POS_W'(MAX_FRAME_BYTES)) ? POS_W'(MAX_FRAME_BYTES - 1) : pos_ff;
      next_pos  = store_pos + 1'b1;
      frame_len = (mode == MODE_SRXL) ? POS_W'(SRXL_LEN) : POS_W'(SBUS_LEN);
      pos_in    = pos_ff;
      hdr_in    = hdr_ff;
      ftr_in    = ftr_ff;
      if (cmd.store) begin
         pos_in = (next_pos >= frame_len) ? '0 : next_pos;
         if (store_pos == '0) begin
            hdr_in = rx_byte;
         end
         if (store_pos == POS_W'(FOOTER_POS)) begin
            ftr_in = rx_byte;
         end
      end
   end

   // Bit unpacking
   always_comb begin
      rd_ptr_in = rd_ptr_ff;
      acc_in    = acc_ff;
      nbits_in  = nbits_ff;
      chan_in   = chan_ff;
      if (cmd.start_decode) begin
         rd_ptr_in = POS_W'(1);
         acc_in    = '0;
         nbits_in  = '0;
         chan_in   = '0;
      end else if (cmd.load_byte) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
         nbits_in  = nbits_ff + NBITS_W'(BYTE_W);
         if (mode == MODE_SRXL) begin
            acc_in = ACC_W'({acc_ff[BYTE_W-1:0], ram_rdata});
         end else begin
            acc_in = acc_ff | (ACC_W'(ram_rdata) << nbits_ff);
         end
      end else if (cmd.emit) begin
         chan_in = chan_ff + 1'b1;
         if (mode == MODE_SRXL) begin
            acc_in   = '0;
            nbits_in = '0;
         end else begin
            acc_in   = acc_ff >> SBUS_W;
            nbits_in = nbits_ff - NBITS_W'(SBUS_W);
         end
      end
   end

   always_comb begin
      if (mode == MODE_SRXL) begin
         raw_value = acc_ff[VALUE_W-1:0];
      end else begin
         raw_value = VALUE_W'({acc_ff[SBUS_W-1:0], 1'b0});
      end
      rev_mask16 = VALUE_W'(reverse_mask) & REV_ENABLE;
      chan_value = rev_mask16[chan_ff] ? (REV_BASE - raw_value) : raw_value;
   end

   // Result register
   always_comb begin
      out_load = cmd.emit | cmd.load_err;
      bad_in   = cmd.load_err ? (bad_ff + 1'b1) : bad_ff;
      valid_in = out_load ? 1'b1 : (rsp_ready ? 1'b0 : valid_ff);
      index_in = index_ff;
      value_in = value_ff;
      good_in  = good_ff;
      total_in = total_ff;
      last_in  = last_ff;
      if (cmd.emit) begin
         index_in = chan_ff;
         value_in = chan_value;
         good_in  = 1'b1;
         total_in = bad_ff;
         last_in  = (chan_ff == CHAN_W'(CHANNEL_COUNT - 1));
      end else if (cmd.load_err) begin
         index_in = '0;
         value_in = '0;
         good_in  = 1'b0;
         total_in = bad_ff + 1'b1;
         last_in  = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         bad_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         pos_ff   <= pos_in;
         bad_ff   <= bad_in;
         valid_ff <= valid_in;
      end
      hdr_ff    <= hdr_in;
      ftr_ff    <= ftr_in;
      rd_ptr_ff <= rd_ptr_in;
      acc_ff    <= acc_in;
      nbits_ff  <= nbits_in;
      chan_ff   <= chan_in;
      index_ff  <= index_in;
      value_ff  <= value_in;
      good_ff   <= good_in;
      total_ff  <= total_in;
      last_ff   <= last_in;
   end

   always_comb begin
      st.frame_done  = next_pos >= frame_len;
      st.frame_ok    = (mode == MODE_SRXL) ? (hdr_ff == SRXL_HEADER) :
                       ((hdr_ff == SBUS_HEADER) && (ftr_ff == SBUS_FOOTER));
      st.bits_enough = (mode == MODE_SRXL) ? (nbits_ff >= NBITS_W'(VALUE_W)) :
                       (nbits_ff >= NBITS_W'(SBUS_W));
      st.last_chan   = (chan_ff == CHAN_W'(CHANNEL_COUNT - 1));
      st.out_free    = !valid_ff || rsp_ready;
   end

   assign rsp_valid         = valid_ff;
   assign rsp_channel_index = index_ff;
   assign rsp_channel_value = value_ff;
   assign rsp_frame_good    = good_ff;
   assign rsp_error_total   = total_ff;
   assign rsp_last_of_frame = last_ff;

   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      pos_ff < POS_W'(MAX_FRAME_BYTES))
      else $error("byte position beyond frame store");

   a_pos_restart: assert property (@(posedge clock) disable iff (reset)
      (cmd.store && st.frame_done) |=> (pos_ff == '0))
      else $error("byte position not restarted after frame end");

   a_err_result: assert property (@(posedge clock) disable iff (reset)
      cmd.load_err |=> (valid_ff && !good_ff && last_ff && (total_ff == bad_ff)))
      else $error("error result malformed");

endmodule

`default_nettype wire

[rtl/core/rcfd_ctrl.sv]
`default_nettype none

module rcfd_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire rcfd_pkg::status_type st,
   output rcfd_pkg::cmd_type         cmd
);

   import rcfd_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.store = 1'b1;
               if (st.frame_done) begin
                  state_in = ST_CHECK;
               end
            end
         end
         ST_CHECK: begin
            if (st.frame_ok) begin
               cmd.start_decode = 1'b1;
               state_in         = ST_FETCH;
            end else begin
               state_in = ST_ERROR;
            end
         end
         ST_ERROR: begin
            if (st.out_free) begin
               cmd.load_err = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_FETCH: begin
            cmd.fetch = 1'b1;
            state_in  = ST_LOAD;
         end
         ST_LOAD: begin
            cmd.load_byte = 1'b1;
            state_in      = ST_EMIT;
         end
         ST_EMIT: begin
            if (!st.bits_enough) begin
               state_in = ST_FETCH;
            end else if (st.out_free) begin
               cmd.emit = 1'b1;
               state_in = st.last_chan ? ST_IDLE : ST_FETCH;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit || cmd.load_err) |-> st.out_free)
      else $error("result loaded over a pending transfer");

   a_frame_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE && req_valid && st.frame_done) |=> (state_ff == ST_CHECK))
      else $error("completed frame not checked");

   a_decode_end: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit && st.last_chan) |=> (state_ff == ST_IDLE && req_ready))
      else $error("decoder did not return to idle after last channel");

endmodule

`default_nettype wire

[rtl/core/rc_frame_channel_decoder.sv]
// A byte that does not end a frame is stored and yields no result.
// A bad frame's error result is loaded in the ERROR state, after CHECK, once the result
// register is free. A good frame is unpacked one stored byte per fetch/load/emit step (22
// bytes for SBUS, 32 for SRXL), and an emit waits while the result register is full; no
// bytes are taken until channel 15 is loaded (single registered RAM read).
// Reset (synchronous, active high) clears position, error count, config and result valid.
`default_nettype none

module rc_frame_channel_decoder (
   input  wire logic                           clock,
   input  wire logic                           reset,
   // Byte input channel
   input  wire logic                           req_valid,
   output logic                                req_ready,
   input  wire logic [rcfd_pkg::BYTE_W-1:0]    req_rx_byte,
   // Channel result channel
   output logic                                rsp_valid,
   input  wire logic                           rsp_ready,
   output logic      [rcfd_pkg::CHAN_W-1:0]    rsp_channel_index,
   output logic      [rcfd_pkg::VALUE_W-1:0]   rsp_channel_value,
   output logic                                rsp_frame_good,
   output logic      [rcfd_pkg::COUNT_W-1:0]   rsp_error_total,
   output logic                                rsp_last_of_frame,
   // APB-style register port
   input  wire logic                           psel,
   input  wire logic                           penable,
   input  wire logic                           pwrite,
   input  wire logic [rcfd_pkg::PADDR_W-1:0]   paddr,
   input  wire logic [rcfd_pkg::PDATA_W-1:0]   pwdata,
   output logic      [rcfd_pkg::PDATA_W-1:0]   prdata,
   output logic                                pready
);

   import rcfd_pkg::*;

   // Register file: mode at word 0, reverse mask at word 1.
   logic              mode_ff, mode_in;
   logic [MASK_W-1:0] mask_ff, mask_in;
   logic              csr_write;
   logic              reg_sel;

   cmd_type           cmd;
   status_type        st;

   // Zero-wait-state port: the access phase always completes.
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;
   assign reg_sel   = paddr[2];

   always_comb begin
      mode_in = mode_ff;
      mask_in = mask_ff;
      if (csr_write) begin
         unique case (reg_sel)
            REG_MODE: mode_in = pwdata[0];
            REG_MASK: mask_in = pwdata[MASK_W-1:0];
            default:  mode_in = mode_ff;
         endcase
      end
   end

   // Read back the addressed register, zero-extended.
   always_comb begin
      unique case (reg_sel)
         REG_MODE: prdata = PDATA_W'(mode_ff);
         REG_MASK: prdata = PDATA_W'(mask_ff);
         default:  prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_SBUS;
         mask_ff <= '0;
      end else begin
         mode_ff <= mode_in;
         mask_ff <= mask_in;
      end
   end

   // Sequencer: accept bytes, check the frame, then step the unpack loop or load an error result.
   rcfd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .st        (st),
      .cmd       (cmd)
   );

   // Frame store, bit unpacker, reversal and the result register.
   rcfd_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .st                (st),
      .mode              (mode_ff),
      .reverse_mask      (mask_ff),
      .rx_byte           (req_rx_byte),
      .rsp_ready         (rsp_ready),
      .rsp_valid         (rsp_valid),
      .rsp_channel_index (rsp_channel_index),
      .rsp_channel_value (rsp_channel_value),
      .rsp_frame_good    (rsp_frame_good),
      .rsp_error_total   (rsp_error_total),
      .rsp_last_of_frame (rsp_last_of_frame)
   );

endmodule

`default_nettype wire
